@@ hw/rtl/environment_map_texel_address_unit_defines.svh @@
// Assertion macros shared by the texel address unit RTL.
// Used by emtau_fifo and emtau_back; expects clock and reset in scope.
`ifndef ENVIRONMENT_MAP_TEXEL_ADDRESS_UNIT_DEFINES_SVH
`define ENVIRONMENT_MAP_TEXEL_ADDRESS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EMTAU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define EMTAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/emtau_pkg.sv @@
// Package for the environment-map texel address unit.
// Widths, codes, the arctangent table and the shared struct types; no dependencies.
`timescale 1ns / 1ps

package emtau_pkg;

   // direction and texture geometry
   localparam int DIR_W         = 16;
   localparam int DIR_FRAC_BITS = 14;
   localparam int SIZE_W        = 13;
   localparam int TEX_MAX       = 4096;
   localparam int COORD_W       = 12;
   localparam int FACE_W        = 3;
   localparam int NUM_W         = 17;

   // square root of 1 - y*y
   localparam int SQ_W        = 2 * DIR_FRAC_BITS + 2;
   localparam int ISQRT_STEPS = SQ_W / 2;
   localparam int ROOT_W      = ISQRT_STEPS;

   // CORDIC vectoring
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_SHIFT = 16;
   localparam int CORDIC_W     = DIR_W + CORDIC_SHIFT + 4;
   localparam int ANG_W        = 18;
   localparam int ANG_OUT_W    = 17;
   localparam int PI_ANG       = 32768;
   localparam int HALF_PI_ANG  = 16384;

   // size * num / den
   localparam int PROD_W    = SIZE_W + NUM_W;
   localparam int QUO_W     = 13;
   localparam int DIV_STEPS = QUO_W;

   // pipeline latencies
   localparam int ISQRT_LAT  = ISQRT_STEPS;
   localparam int CORDIC_LAT = CORDIC_STEPS + 1;
   localparam int SCALE_LAT  = 1 + DIV_STEPS;

   // front/back queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_MAP_MODE    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FACE_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_FACE_HEIGHT = 2'd2;

   // face codes
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd5;

   typedef struct packed {
      logic              sphere;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } cfg_type;

   // classified item as it travels from front to back
   typedef struct packed {
      logic                    zero;
      logic                    sphere;
      logic [FACE_W-1:0]       face;
      logic [NUM_W-1:0]        num_u;
      logic [NUM_W-1:0]        num_v;
      logic [NUM_W-1:0]        den;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
      logic                    y_sat_pos;
      logic                    y_sat_neg;
   } item_type;

   // atan(2^-i)/pi in Q1.15, rounded
   function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(8192);
         1:       val = ANG_W'(4836);
         2:       val = ANG_W'(2555);
         3:       val = ANG_W'(1297);
         4:       val = ANG_W'(651);
         5:       val = ANG_W'(326);
         6:       val = ANG_W'(163);
         7:       val = ANG_W'(81);
         8:       val = ANG_W'(41);
         9:       val = ANG_W'(20);
         10:      val = ANG_W'(10);
         11:      val = ANG_W'(5);
         12:      val = ANG_W'(3);
         13:      val = ANG_W'(1);
         14:      val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/emtau_front.sv @@
// Front end: input handshake and classification of each direction.
// Depends on emtau_pkg; feeds emtau_fifo.
`timescale 1ns / 1ps

module emtau_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic signed [emtau_pkg::DIR_W-1:0] dir_x,
   input  logic signed [emtau_pkg::DIR_W-1:0] dir_y,
   input  logic signed [emtau_pkg::DIR_W-1:0] dir_z,
   input  emtau_pkg::cfg_type               cfg,
   input  logic                             fifo_full,
   output logic                             push,
   output emtau_pkg::item_type              item
);

   localparam int EW = emtau_pkg::DIR_W + 1;
   localparam int TW = emtau_pkg::DIR_W + 2;
   localparam logic signed [emtau_pkg::DIR_W-1:0] ONE =
      emtau_pkg::DIR_W'(1 << emtau_pkg::DIR_FRAC_BITS);

   logic signed [EW-1:0] xe, ye, ze;
   logic [EW-1:0]        ax, ay, az, m;
   logic signed [TW-1:0] tu, tv, ms, nu, nv;
   logic                 fu, fv;
   logic [emtau_pkg::FACE_W-1:0] face;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

   // major axis, face and signed minor components
   always_comb begin
      xe = EW'(dir_x);
      ye = EW'(dir_y);
      ze = EW'(dir_z);
      ax = xe < 0 ? -xe : xe;
      ay = ye < 0 ? -ye : ye;
      az = ze < 0 ? -ze : ze;
      if (ax >= ay && ax >= az) begin
         m    = ax;
         tu   = xe > 0 ? TW'(ze) : -TW'(ze);
         tv   = xe > 0 ? TW'(ye) : -TW'(ye);
         face = xe > 0 ? emtau_pkg::FACE_POS_X : emtau_pkg::FACE_NEG_X;
         fu   = 1'b1;
         fv   = !(xe > 0);
      end else if (ay >= az) begin
         m    = ay;
         tu   = ye > 0 ? TW'(xe) : -TW'(xe);
         tv   = ye > 0 ? TW'(ze) : -TW'(ze);
         face = ye > 0 ? emtau_pkg::FACE_POS_Y : emtau_pkg::FACE_NEG_Y;
         fu   = !(ye > 0);
         fv   = 1'b1;
      end else begin
         m    = az;
         tu   = ze > 0 ? TW'(xe) : -TW'(xe);
         tv   = ze > 0 ? TW'(ye) : -TW'(ye);
         face = ze > 0 ? emtau_pkg::FACE_POS_Z : emtau_pkg::FACE_NEG_Z;
         fu   = 1'b0;
         fv   = !(ze > 0);
      end
      ms = $signed({1'b0, m});
      nu = fu ? ms - tu : ms + tu;
      nv = fv ? ms - tv : ms + tv;
   end

   // pack the classified beat
   always_comb begin
      item.zero      = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
      item.sphere    = cfg.sphere;
      item.face      = cfg.sphere ? emtau_pkg::FACE_POS_Z : face;
      item.num_u     = emtau_pkg::NUM_W'(nu);
      item.num_v     = emtau_pkg::NUM_W'(nv);
      item.den       = emtau_pkg::NUM_W'({m, 1'b0});
      item.dir_x     = dir_x;
      item.dir_y     = dir_y;
      item.dir_z     = dir_z;
      item.y_sat_pos = dir_y >= ONE;
      item.y_sat_neg = dir_y <= -ONE;
   end

endmodule

@@ hw/rtl/emtau_fifo.sv @@
// Short queue of classified items between front and back end.
// Depends on emtau_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "environment_map_texel_address_unit_defines.svh"

module emtau_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  emtau_pkg::item_type item_wr,
   input  logic                pop,
   output emtau_pkg::item_type item_rd,
   output logic                full,
   output logic                empty
);

   emtau_pkg::item_type                mem_ff [emtau_pkg::FIFO_DEPTH];
   logic [emtau_pkg::FIFO_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [emtau_pkg::FIFO_CW-1:0]      count_ff;

   assign full    = count_ff == emtau_pkg::FIFO_CW'(emtau_pkg::FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign item_rd = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_wr;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `EMTAU_ASSERT_NOW(a_fifo_no_overflow, push, !full, "queue written while full")
   `EMTAU_ASSERT_NOW(a_fifo_no_underflow, pop, !empty, "queue read while empty")
   `EMTAU_ASSERT_NOW(a_fifo_count_range, 1'b1, count_ff <= emtau_pkg::FIFO_CW'(emtau_pkg::FIFO_DEPTH), "queue fill level out of range")

endmodule

@@ hw/rtl/emtau_isqrt.sv @@
// Pipelined integer square root, two radicand bits per stage.
// Depends on emtau_pkg.
`timescale 1ns / 1ps

module emtau_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [emtau_pkg::SQ_W-1:0]    rad_in,
   output logic [emtau_pkg::ROOT_W-1:0]  root_out
);

   localparam int SW = emtau_pkg::SQ_W;
   localparam int RW = emtau_pkg::ROOT_W;
   localparam int N  = emtau_pkg::ISQRT_STEPS;

   logic [SW-1:0] rad_ff  [N];
   logic [RW:0]   rem_ff  [N];
   logic [RW-1:0] root_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [SW-1:0] rad_p;
      logic [RW:0]   rem_p;
      logic [RW-1:0] root_p;
      logic [RW+2:0] rem_sh, trial;

      if (k == 0) begin : g_first
         assign rad_p  = rad_in;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
      end

      // bring down two bits, try root*4+1
      assign rem_sh = {rem_p, rad_p[SW-1 -: 2]};
      assign trial  = (RW+3)'({root_p, 2'b01});

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k] <= rad_p << 2;
            if (rem_sh >= trial) begin
               rem_ff[k]  <= (RW+1)'(rem_sh - trial);
               root_ff[k] <= {root_p[RW-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= (RW+1)'(rem_sh);
               root_ff[k] <= {root_p[RW-2:0], 1'b0};
            end
         end
      end
   end

   assign root_out = root_ff[N-1];

endmodule

@@ hw/rtl/emtau_cordic.sv @@
// Pipelined CORDIC vectoring: atan2(b, a) as a fraction of pi.
// Depends on emtau_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module emtau_cordic (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [emtau_pkg::DIR_W-1:0]   b_in,
   input  logic signed [emtau_pkg::DIR_W-1:0]   a_in,
   output logic signed [emtau_pkg::ANG_OUT_W-1:0] ang_out
);

   localparam int CW = emtau_pkg::CORDIC_W;
   localparam int AW = emtau_pkg::ANG_W;
   localparam int N  = emtau_pkg::CORDIC_STEPS;
   localparam logic signed [AW-1:0] ANG_PI = AW'(emtau_pkg::PI_ANG);

   logic signed [CW-1:0] x_ff   [N+1];
   logic signed [CW-1:0] y_ff   [N+1];
   logic signed [AW-1:0] ang_ff [N+1];

   logic signed [CW-1:0] a_ext, b_ext;
   logic signed [AW-1:0] ang_end;

   // prescale; left half-plane is folded by negation with a pi offset
   assign a_ext = CW'(a_in) <<< emtau_pkg::CORDIC_SHIFT;
   assign b_ext = CW'(b_in) <<< emtau_pkg::CORDIC_SHIFT;

   always_ff @(posedge clock) begin
      if (en) begin
         if (a_in < 0) begin
            x_ff[0]   <= -a_ext;
            y_ff[0]   <= -b_ext;
            ang_ff[0] <= (b_in >= 0) ? ANG_PI : -ANG_PI;
         end else begin
            x_ff[0]   <= a_ext;
            y_ff[0]   <= b_ext;
            ang_ff[0] <= '0;
         end
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [CW-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1]   <= x_ff[i] + dx;
               y_ff[i+1]   <= y_ff[i] - dy;
               ang_ff[i+1] <= ang_ff[i] + emtau_pkg::atan_step(i);
            end else begin
               x_ff[i+1]   <= x_ff[i] - dx;
               y_ff[i+1]   <= y_ff[i] + dy;
               ang_ff[i+1] <= ang_ff[i] - emtau_pkg::atan_step(i);
            end
         end
      end
   end

   // clamp to [-pi, pi]
   always_comb begin
      ang_end = ang_ff[N];
      if (ang_end > ANG_PI) begin
         ang_end = ANG_PI;
      end else if (ang_end < -ANG_PI) begin
         ang_end = -ANG_PI;
      end
   end

   assign ang_out = emtau_pkg::ANG_OUT_W'(ang_end);

endmodule

@@ hw/rtl/emtau_scale.sv @@
// Texel coordinate: floor(size * num / den), saturated to size-1.
// Multiply stage then a pipelined restoring divider; depends on emtau_pkg.
`timescale 1ns / 1ps

module emtau_scale (
   input  logic                              clock,
   input  logic                              en,
   input  logic [emtau_pkg::SIZE_W-1:0]      size_in,
   input  logic [emtau_pkg::NUM_W-1:0]       num_in,
   input  logic [emtau_pkg::NUM_W-1:0]       den_in,
   output logic [emtau_pkg::COORD_W-1:0]     coord_out
);

   localparam int PW = emtau_pkg::PROD_W;
   localparam int QW = emtau_pkg::QUO_W;
   localparam int SW = emtau_pkg::SIZE_W;
   localparam int NW = emtau_pkg::NUM_W;
   localparam int N  = emtau_pkg::DIV_STEPS;

   logic [PW-1:0] rem_ff  [N+1];
   logic [QW-1:0] quo_ff  [N+1];
   logic [NW-1:0] den_ff  [N+1];
   logic [SW-1:0] size_ff [N+1];

   logic [SW-1:0] lim;

   // product stage
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= PW'(size_in * num_in);
         quo_ff[0]  <= '0;
         den_ff[0]  <= den_in;
         size_ff[0] <= size_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < N; k++) begin : g_div
      localparam int B = N - 1 - k;
      logic [PW-1:0] trial;
      assign trial = PW'(den_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            size_ff[k+1] <= size_ff[k];
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1] <= rem_ff[k] - trial;
               quo_ff[k+1] <= quo_ff[k] | (QW'(1) << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   // saturate to size-1 (size is at least 1 and at most 4096)
   assign lim       = size_ff[N] - 1'b1;
   assign coord_out = emtau_pkg::COORD_W'((QW'(quo_ff[N]) > QW'(lim)) ? lim : quo_ff[N]);

endmodule

@@ hw/rtl/emtau_back.sv @@
// Back end: sphere angles, coordinate scaling and the result register.
// Depends on emtau_pkg, emtau_isqrt, emtau_cordic, emtau_scale and the macros.
`timescale 1ns / 1ps
`include "environment_map_texel_address_unit_defines.svh"

module emtau_back (
   input  logic                               clock,
   input  logic                               reset,
   input  emtau_pkg::cfg_type                 cfg,
   input  logic                               fifo_empty,
   input  emtau_pkg::item_type                head_item,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [emtau_pkg::FACE_W-1:0]       face_index,
   output logic [emtau_pkg::COORD_W-1:0]      texel_col,
   output logic [emtau_pkg::COORD_W-1:0]      texel_row,
   output logic                               zero_direction
);

   localparam int T_CORD_IN = 1 + emtau_pkg::ISQRT_LAT;
   localparam int T_PRE     = T_CORD_IN + emtau_pkg::CORDIC_LAT;
   localparam int T_SEL     = T_PRE + 1;
   localparam int LAST      = T_SEL + emtau_pkg::SCALE_LAT;
   localparam int SIDE_LEN  = LAST + 1;

   localparam int SQ_W = emtau_pkg::SQ_W;
   localparam int NW   = emtau_pkg::NUM_W;
   localparam int OW   = emtau_pkg::ANG_OUT_W;
   localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * emtau_pkg::DIR_FRAC_BITS);

   emtau_pkg::item_type sd_ff  [SIDE_LEN];
   logic                vld_ff [SIDE_LEN];

   logic                en;
   logic [SQ_W-1:0]     rem_ff, rem_in;
   logic signed [2*emtau_pkg::DIR_W-1:0] ysq;
   logic [emtau_pkg::ROOT_W-1:0]         root;
   logic signed [OW-1:0] ang_a, ang_b, b_sel;
   logic signed [OW:0]   sum_c, sum_r;
   logic [NW-1:0]        num_c_ff, num_r_ff, den_c_ff, den_r_ff;
   logic [NW-1:0]        num_c_in, num_r_in, den_c_in, den_r_in;
   logic [emtau_pkg::COORD_W-1:0] col_q, row_q;

   logic                           rsp_valid_ff;
   logic [emtau_pkg::FACE_W-1:0]   face_ff;
   logic [emtau_pkg::COORD_W-1:0]  col_ff, row_ff;
   logic                           zero_ff;

   // whole pipeline moves when the result register can take a beat
   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && !fifo_empty;

   // item sideband and valid chain
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= head_item;
         for (int k = 1; k < SIDE_LEN; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_LEN; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= !fifo_empty;
         for (int k = 1; k < SIDE_LEN; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // 1 - y*y in units of 2^-2F
   assign ysq    = sd_ff[0].dir_y * sd_ff[0].dir_y;
   assign rem_in = ONE_SQ - ysq[SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
      end
   end

   emtau_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (rem_ff),
      .root_out (root)
   );

   // atan2(z, x) for the column
   emtau_cordic u_cordic_u (
      .clock   (clock),
      .en      (en),
      .b_in    (sd_ff[T_CORD_IN].dir_z),
      .a_in    (sd_ff[T_CORD_IN].dir_x),
      .ang_out (ang_a)
   );

   // asin(y) = atan2(y, sqrt(1 - y*y)) for the row
   emtau_cordic u_cordic_v (
      .clock   (clock),
      .en      (en),
      .b_in    (sd_ff[T_CORD_IN].dir_y),
      .a_in    (emtau_pkg::DIR_W'(root)),
      .ang_out (ang_b)
   );

   // numerator and denominator select for both coordinates
   always_comb begin
      if (sd_ff[T_PRE].y_sat_pos) begin
         b_sel = OW'(emtau_pkg::HALF_PI_ANG);
      end else if (sd_ff[T_PRE].y_sat_neg) begin
         b_sel = -OW'(emtau_pkg::HALF_PI_ANG);
      end else begin
         b_sel = ang_b;
      end
      sum_c = (OW+1)'(ang_a) + (OW+1)'(emtau_pkg::PI_ANG);
      sum_r = (OW+1)'(b_sel) + (OW+1)'(emtau_pkg::HALF_PI_ANG);
      if (sd_ff[T_PRE].sphere) begin
         num_c_in = sum_c < 0 ? '0 : NW'(sum_c);
         num_r_in = sum_r < 0 ? '0 : NW'(sum_r);
         den_c_in = NW'(2 * emtau_pkg::PI_ANG);
         den_r_in = NW'(emtau_pkg::PI_ANG);
      end else begin
         num_c_in = sd_ff[T_PRE].num_u;
         num_r_in = sd_ff[T_PRE].num_v;
         den_c_in = sd_ff[T_PRE].den;
         den_r_in = sd_ff[T_PRE].den;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_c_ff <= num_c_in;
         num_r_ff <= num_r_in;
         den_c_ff <= den_c_in;
         den_r_ff <= den_r_in;
      end
   end

   emtau_scale u_scale_col (
      .clock     (clock),
      .en        (en),
      .size_in   (cfg.width),
      .num_in    (num_c_ff),
      .den_in    (den_c_ff),
      .coord_out (col_q)
   );

   emtau_scale u_scale_row (
      .clock     (clock),
      .en        (en),
      .size_in   (cfg.height),
      .num_in    (num_r_ff),
      .den_in    (den_r_ff),
      .coord_out (row_q)
   );

   // result register; a zero direction reports all zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= sd_ff[LAST].zero;
         face_ff <= sd_ff[LAST].zero ? emtau_pkg::FACE_POS_Z : sd_ff[LAST].face;
         col_ff  <= sd_ff[LAST].zero ? '0 : col_q;
         row_ff  <= sd_ff[LAST].zero ? '0 : row_q;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign face_index     = face_ff;
   assign texel_col      = col_ff;
   assign texel_row      = row_ff;
   assign zero_direction = zero_ff;

   `EMTAU_ASSERT_NOW(a_zero_clean, rsp_valid_ff && zero_ff,
      face_ff == '0 && col_ff == '0 && row_ff == '0, "zero direction with nonzero address")
   `EMTAU_ASSERT_NOW(a_face_range, rsp_valid_ff,
      face_ff <= emtau_pkg::FACE_NEG_Y, "face code out of range")
   `EMTAU_ASSERT_NEXT(a_last_to_out, en && vld_ff[LAST], rsp_valid_ff,
      "finished item did not reach result register")

endmodule

@@ hw/rtl/environment_map_texel_address_unit.sv @@
// Top level of the environment-map texel address unit: register port and wiring.
// Depends on emtau_pkg, emtau_front, emtau_fifo and emtau_back.
//
//   channel | role          | payload
//   --------+---------------+---------------------------------------------------
//   req_*   | stream in     | tdata: dir_x[15:0] dir_y[31:16] dir_z[47:32]
//   rsp_*   | stream out    | tdata: face, col, row; tuser: zero_direction
//   csr_*   | register port | 0 map_mode, 4 face_width, 8 face_height
//
// One direction per clock sustained while the result side accepts; a beat passes
// from acceptance to result through the square-root, CORDIC and divider stages.
// Synchronous active-high reset clears control state and loads register defaults.
// A stalled result holds the back pipeline; the four-entry queue keeps the
// input side accepting until it fills.
`timescale 1ns / 1ps

module environment_map_texel_address_unit (
   input  logic                                clock,
   input  logic                                reset,
   // direction beats
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,   // dir_x, dir_y, dir_z
   // result beats
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // face_index, texel_col, texel_row
   output logic [0:0]                          rsp_tuser,   // zero_direction
   // registers
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [emtau_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [emtau_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [emtau_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int SW = emtau_pkg::SIZE_W;

   logic                  map_mode_ff;
   logic [SW-1:0]         face_width_ff, face_height_ff;
   logic                  csr_wr;
   logic [emtau_pkg::REG_IDX_W-1:0] reg_idx;
   emtau_pkg::cfg_type    cfg;

   logic                  push, pop, fifo_full, fifo_empty;
   emtau_pkg::item_type   item_wr, item_rd;

   logic [emtau_pkg::FACE_W-1:0]  face_index;
   logic [emtau_pkg::COORD_W-1:0] texel_col, texel_row;
   logic                          zero_direction;

   // register port
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[emtau_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff    <= 1'b0;
         face_width_ff  <= SW'(1024);
         face_height_ff <= SW'(1024);
      end else if (csr_wr) begin
         unique case (reg_idx)
            emtau_pkg::REG_MAP_MODE:    map_mode_ff    <= csr_pwdata[0];
            emtau_pkg::REG_FACE_WIDTH:  face_width_ff  <= csr_pwdata[SW-1:0];
            emtau_pkg::REG_FACE_HEIGHT: face_height_ff <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         emtau_pkg::REG_MAP_MODE:    csr_prdata = emtau_pkg::CSR_DATA_W'(map_mode_ff);
         emtau_pkg::REG_FACE_WIDTH:  csr_prdata = emtau_pkg::CSR_DATA_W'(face_width_ff);
         emtau_pkg::REG_FACE_HEIGHT: csr_prdata = emtau_pkg::CSR_DATA_W'(face_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // sizes clamped to [1, TEX_MAX]
   always_comb begin
      cfg.sphere = map_mode_ff;
      if (face_width_ff == '0) begin
         cfg.width = SW'(1);
      end else if (face_width_ff > SW'(emtau_pkg::TEX_MAX)) begin
         cfg.width = SW'(emtau_pkg::TEX_MAX);
      end else begin
         cfg.width = face_width_ff;
      end
      if (face_height_ff == '0) begin
         cfg.height = SW'(1);
      end else if (face_height_ff > SW'(emtau_pkg::TEX_MAX)) begin
         cfg.height = SW'(emtau_pkg::TEX_MAX);
      end else begin
         cfg.height = face_height_ff;
      end
   end

   emtau_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dir_x      (req_tdata[15:0]),
      .dir_y      (req_tdata[31:16]),
      .dir_z      (req_tdata[47:32]),
      .cfg        (cfg),
      .fifo_full  (fifo_full),
      .push       (push),
      .item       (item_wr)
   );

   emtau_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .item_wr (item_wr),
      .pop     (pop),
      .item_rd (item_rd),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   emtau_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fifo_empty     (fifo_empty),
      .head_item      (item_rd),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .face_index     (face_index),
      .texel_col      (texel_col),
      .texel_row      (texel_row),
      .zero_direction (zero_direction)
   );

   assign rsp_tdata = {5'b0, texel_row, texel_col, face_index};
   assign rsp_tuser = zero_direction;

endmodule
